@@ hdl/pdsx_pkg.sv @@
// Shared constants, types and inverse substitution table for the packet decryptor.
`timescale 1ns / 1ps

package pdsx_pkg;

    localparam logic [2:0]  HDR_BYTES       = 3'd4;
    localparam logic [31:0] KEY_MASK        = 32'hA55AA55A;
    localparam logic [17:0] LCG_MUL         = 18'd241103;
    localparam logic [31:0] LCG_ADD         = 32'd2533101;
    localparam logic [7:0]  ROUND_STEP      = 8'd3;
    localparam logic [31:0] SESSION_KEY_RST = 32'h12345678;
    localparam int          WORD_BYTES      = 4;

    localparam logic [7:0] INV_TABLE [0:255] = '{
        8'h51,8'hA1,8'h9E,8'hB0,8'h1E,8'h83,8'h1C,8'h2D,8'hE9,8'h77,8'h3D,8'h13,8'h93,8'h10,8'h45,8'hFF,
        8'h6D,8'hC9,8'h20,8'h2F,8'h1B,8'h82,8'h1A,8'h7D,8'hF5,8'hCF,8'h52,8'hA8,8'hD2,8'hA4,8'hB4,8'h0B,
        8'h31,8'h97,8'h57,8'h19,8'h34,8'hDF,8'h5B,8'h41,8'h58,8'h49,8'hAA,8'h5F,8'h0A,8'hEF,8'h88,8'h01,
        8'hDC,8'h95,8'hD4,8'hAF,8'h7B,8'hE3,8'h11,8'h8E,8'h9D,8'h16,8'h61,8'h8C,8'h84,8'h3C,8'h1F,8'h5A,
        8'h02,8'h4F,8'h39,8'hFE,8'h04,8'h07,8'h5C,8'h8B,8'hEE,8'h66,8'h33,8'hC4,8'hC8,8'h59,8'hB5,8'h5D,
        8'hC2,8'h6C,8'hF6,8'h4D,8'hFB,8'hAE,8'h4A,8'h4B,8'hF3,8'h35,8'h2C,8'hCA,8'h21,8'h78,8'h3B,8'h03,
        8'hFD,8'h24,8'hBD,8'h25,8'h37,8'h29,8'hAC,8'h4E,8'hF9,8'h92,8'h3A,8'h32,8'h4C,8'hDA,8'h06,8'h5E,
        8'h00,8'h94,8'h60,8'hEC,8'h17,8'h98,8'hD7,8'h3E,8'hCB,8'h6A,8'hA9,8'hD9,8'h9C,8'hBB,8'h08,8'h8F,
        8'h40,8'hA0,8'h6F,8'h55,8'h67,8'h87,8'h54,8'h80,8'hB2,8'h36,8'h47,8'h22,8'h44,8'h63,8'h05,8'h6B,
        8'hF0,8'h0F,8'hC7,8'h90,8'hC5,8'h65,8'hE2,8'h64,8'hFA,8'hD5,8'hDB,8'h12,8'h7A,8'h0E,8'hD8,8'h7E,
        8'h99,8'hD1,8'hE8,8'hD6,8'h86,8'h27,8'hBF,8'hC1,8'h6E,8'hDE,8'h9A,8'h09,8'h0D,8'hAB,8'hE1,8'h91,
        8'h56,8'hCD,8'hB3,8'h76,8'h0C,8'hC3,8'hD3,8'h9F,8'h42,8'hB6,8'h9B,8'hE5,8'h23,8'hA7,8'hAD,8'h18,
        8'hC6,8'hF4,8'hB8,8'hBE,8'h15,8'h43,8'h70,8'hE0,8'hE7,8'hBC,8'hF1,8'hBA,8'hA5,8'hA6,8'h53,8'h75,
        8'hE4,8'hEB,8'hE6,8'h85,8'h14,8'h48,8'hDD,8'h38,8'h2A,8'hCC,8'h7F,8'hB1,8'hC0,8'h71,8'h96,8'hF8,
        8'h3F,8'h28,8'hF2,8'h69,8'h74,8'h68,8'hB7,8'hA3,8'h50,8'hD0,8'h79,8'h1D,8'hFC,8'hCE,8'h8A,8'h8D,
        8'h2E,8'h62,8'h30,8'hEA,8'hED,8'h2B,8'h26,8'hB9,8'h81,8'h7C,8'h46,8'h89,8'h73,8'hA2,8'hF7,8'h72
    };

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       packet_end;
        logic       check_error;
    } t_result;

    typedef struct packed {
        logic [2:0]                    cnt;
        t_result [WORD_BYTES-1:0]      ent;
    } t_push;

endpackage

@@ hdl/pdsx_word_decrypt.sv @@
// Word decrypt: key XOR, inverse substitution, round offset, check sums and next key.
`timescale 1ns / 1ps

module pdsx_word_decrypt (
    input  logic [31:0]     i_word,
    input  logic [31:0]     i_key,
    input  logic [7:0]      i_round,
    input  logic [7:0]      i_csum,
    output logic [3:0][7:0] o_plain,
    output logic [3:0][7:0] o_sum,
    output logic [31:0]     o_next_key
);

    logic [31:0] w_xor;
    logic [33:0] w_prod_hi;
    logic [33:0] w_prod_lo;
    logic [31:0] w_lcg_hi;
    logic [31:0] w_lcg_lo;

    assign w_xor = i_word ^ i_key;

    always_comb begin
        logic [7:0] acc;
        logic [7:0] rnd;
        acc = i_csum;
        rnd = i_round;
        for (int k = 0; k < pdsx_pkg::WORD_BYTES; k++) begin
            o_plain[k] = pdsx_pkg::INV_TABLE[w_xor[8*k +: 8]] - rnd;
            acc        = acc + o_plain[k];
            o_sum[k]   = acc;
            rnd        = rnd + pdsx_pkg::ROUND_STEP;
        end
    end

    assign w_prod_hi  = 34'(i_word[31:16]) * 34'(pdsx_pkg::LCG_MUL);
    assign w_prod_lo  = 34'(i_word[15:0])  * 34'(pdsx_pkg::LCG_MUL);
    assign w_lcg_hi   = w_prod_hi[31:0] + pdsx_pkg::LCG_ADD;
    assign w_lcg_lo   = w_prod_lo[31:0] + pdsx_pkg::LCG_ADD;
    assign o_next_key = {w_lcg_hi[31:16], w_lcg_lo[31:16]} ^ pdsx_pkg::KEY_MASK;

endmodule

@@ hdl/pdsx_result_queue.sv @@
// Result queue: takes up to four results per cycle, sends one per transfer.
`timescale 1ns / 1ps

module pdsx_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdsx_pkg::t_push   i_push,
    output logic              o_room,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // plain_byte
    output logic              m_axis_tlast,  // packet_end
    output logic              m_axis_tuser   // check_error
);

    localparam int DEPTH = 8;
    localparam int AW    = $clog2(DEPTH);

    pdsx_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic [AW:0]       n_count;
    logic              w_pop;

    assign w_pop         = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_mem[r_rd_ptr].plain_byte;
    assign m_axis_tlast  = r_mem[r_rd_ptr].packet_end;
    assign m_axis_tuser  = r_mem[r_rd_ptr].check_error;
    assign o_room        = (r_count <= (AW+1)'(DEPTH - pdsx_pkg::WORD_BYTES));
    assign n_count       = r_count + (AW+1)'(i_push.cnt) - (AW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < pdsx_pkg::WORD_BYTES; k++) begin
            if (3'(k) < i_push.cnt) begin
                r_mem[r_wr_ptr + AW'(k)] <= i_push.ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + AW'(w_pop);
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/packet_decrypt_substitute_xor_core.sv @@
// Top level of the receive-side packet decryptor.
`timescale 1ns / 1ps

// Byte-serial packet decryptor.
// Input stream s_axis: one received byte per transfer; tlast marks the packet's
// final byte, tuser marks the first byte of a new session (reload key, clear round).
// Output stream m_axis: one result byte per transfer; tlast marks the packet's last
// result, tuser flags a nonzero check sum on it or a packet ending in its header.
// Configuration channel i_cfg_*: the session key, taken at any time (o_cfg_ready
// is always high); write it only while the block is idle.
// Header bytes give one result each. Payload bytes gather into 32-bit words; a word
// decrypts in the cycle its last byte is taken and its four results (or fewer for a
// short final word) enter an eight-entry result queue.
// Throughput: one input byte per cycle sustained; the queue drains one result per
// cycle, so s_axis_tready stays high as long as the receiver keeps taking results.
// s_axis_tready drops when the queue holds more than four results, i.e. when the
// receiver stalls; queued results hold until taken.
// Reset (synchronous, active low) clears the key state, round, framing and queue,
// and sets the session key to 0x12345678.

module packet_decrypt_substitute_xor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,   // session_key
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata, // cipher_byte
    input  logic        s_axis_tlast, // last_byte
    input  logic        s_axis_tuser, // session_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata, // plain_byte
    output logic        m_axis_tlast, // packet_end
    output logic        m_axis_tuser  // check_error
);

    logic [31:0] r_session_key;
    logic [31:0] r_running_key;
    logic [7:0]  r_round;
    logic [23:0] r_held;
    logic [1:0]  r_lane;
    logic [2:0]  r_hdr;
    logic [7:0]  r_csum;

    logic [31:0] n_running_key;
    logic [7:0]  n_round;
    logic [23:0] n_held;
    logic [1:0]  n_lane;
    logic [2:0]  n_hdr;
    logic [7:0]  n_csum;

    logic [31:0] w_key;
    logic [7:0]  w_round;
    logic [23:0] w_held;
    logic [1:0]  w_lane;
    logic [2:0]  w_hdr;
    logic [7:0]  w_csum;
    logic        w_accept;
    logic        w_is_hdr;
    logic        w_emit;
    logic [2:0]  w_cnt;
    logic [31:0] w_word;
    logic [3:0][7:0] w_plain;
    logic [3:0][7:0] w_sum;
    logic [31:0] w_next_key;
    logic        w_room;
    pdsx_pkg::t_push w_push;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_room;
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    assign w_key    = s_axis_tuser ? r_session_key : r_running_key;
    assign w_round  = s_axis_tuser ? 8'd0  : r_round;
    assign w_held   = s_axis_tuser ? 24'd0 : r_held;
    assign w_lane   = s_axis_tuser ? 2'd0  : r_lane;
    assign w_hdr    = s_axis_tuser ? 3'd0  : r_hdr;
    assign w_csum   = s_axis_tuser ? 8'd0  : r_csum;

    assign w_is_hdr = (w_hdr < pdsx_pkg::HDR_BYTES);
    assign w_emit   = !w_is_hdr && ((w_lane == 2'd3) || s_axis_tlast);
    assign w_cnt    = {1'b0, w_lane} + 3'd1;

    always_comb begin
        logic [31:0] ext;
        ext = {8'h00, w_held};
        for (int k = 0; k < pdsx_pkg::WORD_BYTES; k++) begin
            if (2'(k) < w_lane || k == 3 && w_lane == 2'd3) begin
                w_word[8*k +: 8] = (2'(k) == w_lane) ? s_axis_tdata : ext[8*k +: 8];
            end else if (2'(k) == w_lane) begin
                w_word[8*k +: 8] = s_axis_tdata;
            end else begin
                w_word[8*k +: 8] = w_key[8*k +: 8];
            end
        end
    end

    pdsx_word_decrypt u_word (
        .i_word     (w_word),
        .i_key      (w_key),
        .i_round    (w_round),
        .i_csum     (w_csum),
        .o_plain    (w_plain),
        .o_sum      (w_sum),
        .o_next_key (w_next_key)
    );

    always_comb begin
        w_push = '0;
        if (w_accept && w_is_hdr) begin
            w_push.cnt                = 3'd1;
            w_push.ent[0].plain_byte  = s_axis_tdata;
            w_push.ent[0].packet_end  = s_axis_tlast;
            w_push.ent[0].check_error = s_axis_tlast;
        end else if (w_accept && w_emit) begin
            w_push.cnt = w_cnt;
            for (int k = 0; k < pdsx_pkg::WORD_BYTES; k++) begin
                w_push.ent[k].plain_byte  = w_plain[k];
                w_push.ent[k].packet_end  = s_axis_tlast && (3'(k) == w_cnt - 3'd1);
                w_push.ent[k].check_error = s_axis_tlast && (3'(k) == w_cnt - 3'd1)
                                            && (w_sum[k] != 8'd0);
            end
        end
    end

    always_comb begin
        n_running_key = w_key;
        n_round       = w_round;
        n_held        = w_held;
        n_lane        = w_lane;
        n_hdr         = w_hdr;
        n_csum        = w_csum;
        if (w_is_hdr) begin
            n_hdr = w_hdr + 3'd1;
            if (w_hdr == 3'd1) begin
                n_csum = w_csum + s_axis_tdata;
            end
        end else if (w_emit) begin
            n_running_key = w_next_key;
            n_round       = w_round + 8'(w_cnt) * pdsx_pkg::ROUND_STEP;
            n_held        = '0;
            n_lane        = '0;
            n_csum        = w_sum[w_lane];
        end else begin
            n_lane = w_lane + 2'd1;
            unique case (w_lane)
                2'd0:    n_held[7:0]   = s_axis_tdata;
                2'd1:    n_held[15:8]  = s_axis_tdata;
                2'd2:    n_held[23:16] = s_axis_tdata;
                default: n_held        = w_held;
            endcase
        end
        if (s_axis_tlast) begin
            n_held = '0;
            n_lane = '0;
            n_hdr  = '0;
            n_csum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_key <= pdsx_pkg::SESSION_KEY_RST;
            r_running_key <= '0;
            r_round       <= '0;
            r_held        <= '0;
            r_lane        <= '0;
            r_hdr         <= '0;
            r_csum        <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_session_key <= i_cfg_data;
            end
            if (w_accept) begin
                r_running_key <= n_running_key;
                r_round       <= n_round;
                r_held        <= n_held;
                r_lane        <= n_lane;
                r_hdr         <= n_hdr;
                r_csum        <= n_csum;
            end
        end
    end

    pdsx_result_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .o_room        (w_room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the byte-serial packet decryptor core.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT    = 200_000;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          PHASE_ITEMS    = 80;
    localparam int          DIRECTED_ROWS  = 25;

    typedef struct packed {
        logic [31:0] sess_key;
        logic [31:0] run_key;
        logic [7:0]  round;
        logic [23:0] held;
        logic [1:0]  lane;
        logic [2:0]  hdr;
        logic [7:0]  csum;
    } t_dec_state;

    typedef struct packed {
        logic [7:0]        cipher;
        logic              last;
        logic              start;
        logic              fixed;
        pdsx_pkg::t_result want;
    } t_stim_row;

    // cipher, last, start, fixed, then plain_byte, packet_end, check_error when fixed
    localparam t_stim_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        {8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'h7F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'hA5, 1'b0, 1'b1, 1'b1, 8'hA5, 1'b0, 1'b0},
        {8'h5A, 1'b0, 1'b0, 1'b1, 8'h5A, 1'b0, 1'b0},
        {8'h02, 1'b0, 1'b0, 1'b1, 8'h02, 1'b0, 1'b0},
        {8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
        {8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'h01, 1'b0, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0},
        {8'h02, 1'b0, 1'b0, 1'b1, 8'h02, 1'b0, 1'b0},
        {8'h03, 1'b0, 1'b0, 1'b1, 8'h03, 1'b0, 1'b0},
        {8'h04, 1'b1, 1'b0, 1'b1, 8'h04, 1'b1, 1'b1},
        {8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1},
        {8'h10, 1'b0, 1'b0, 1'b1, 8'h10, 1'b0, 1'b0},
        {8'h20, 1'b0, 1'b0, 1'b1, 8'h20, 1'b0, 1'b0},
        {8'h30, 1'b0, 1'b0, 1'b1, 8'h30, 1'b0, 1'b0},
        {8'h40, 1'b0, 1'b0, 1'b1, 8'h40, 1'b0, 1'b0},
        {8'hC3, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        {8'h3C, 1'b0, 1'b1, 1'b1, 8'h3C, 1'b0, 1'b0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    t_dec_state        dec;
    pdsx_pkg::t_result pending_plain [$];
    int unsigned cycle_count   = 0;
    int unsigned n_failures    = 0;
    int          items_sent    = 0;
    int          tx_idle_pct   = 0;
    int          rx_stall_pct  = 0;
    bit          rx_hold_req   = 1'b0;
    bit          pkt_open      = 1'b0;

    packet_decrypt_substitute_xor_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [15:0] half_lcg(input logic [15:0] h);
        logic [31:0] v;
        v = {16'h0000, h} * 32'(pdsx_pkg::LCG_MUL) + pdsx_pkg::LCG_ADD;
        return v[31:16];
    endfunction

    function automatic void clear_framing();
        dec.held = '0;
        dec.lane = '0;
        dec.hdr  = '0;
        dec.csum = '0;
    endfunction

    function automatic pdsx_pkg::t_push decrypt_step(input logic [7:0] c,
                                                     input logic last, start);
        pdsx_pkg::t_push out;
        logic [31:0] word;
        logic [31:0] plain;
        logic [31:0] mask;
        logic [2:0]  n;
        logic [7:0]  m;
        out = '0;
        if (start) begin
            dec.run_key = dec.sess_key;
            dec.round   = '0;
            clear_framing();
        end
        if (dec.hdr < pdsx_pkg::HDR_BYTES) begin
            if (dec.hdr == 3'd1) dec.csum = dec.csum + c;
            dec.hdr = dec.hdr + 3'd1;
            out.cnt = 3'd1;
            out.ent[0].plain_byte  = c;
            out.ent[0].packet_end  = last;
            out.ent[0].check_error = last;
            if (last) clear_framing();
            return out;
        end
        n    = {1'b0, dec.lane} + 3'd1;
        word = {8'h00, dec.held} | ({24'h000000, c} << (8 * dec.lane));
        if (n < 3'd4 && !last) begin
            dec.held = word[23:0];
            dec.lane = n[1:0];
            return out;
        end
        if (n < 3'd4) begin
            mask = (32'h1 << (8 * n)) - 32'h1;
            word = (word & mask) | (dec.run_key & ~mask);
        end
        plain       = word ^ dec.run_key;
        dec.run_key = {half_lcg(word[31:16]), half_lcg(word[15:0])} ^ pdsx_pkg::KEY_MASK;
        for (int k = 0; k < n; k++) begin
            m         = pdsx_pkg::INV_TABLE[plain[8*k +: 8]] - dec.round;
            dec.round = dec.round + pdsx_pkg::ROUND_STEP;
            dec.csum  = dec.csum + m;
            out.ent[k].plain_byte = m;
        end
        out.cnt = n;
        if (last) begin
            out.ent[n-1].packet_end  = 1'b1;
            out.ent[n-1].check_error = (dec.csum != 8'h00);
            clear_framing();
        end else begin
            dec.held = '0;
            dec.lane = '0;
        end
        return out;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic last, start,
                             input logic fixed, input pdsx_pkg::t_result want);
        pdsx_pkg::t_push pr;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pr = decrypt_step(c, last, start);
        if (fixed) begin
            pending_plain.push_back(want);
        end else begin
            for (int k = 0; k < pr.cnt; k++) pending_plain.push_back(pr.ent[k]);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input bit force_start);
        logic [7:0]      pkt [$];
        int              kind;
        int              plen;
        int              nbytes;
        bit              start;
        bit              drop_last;
        bit              good_check;
        logic [7:0]      sum;
        pdsx_pkg::t_push pr;
        t_dec_state      saved;
        kind       = $urandom_range(99);
        start      = force_start || ($urandom_range(2) == 0);
        drop_last  = 1'b0;
        good_check = 1'b0;
        if (kind < 8) begin
            nbytes = $urandom_range(4, 1);
            repeat (nbytes) pkt.push_back(8'($urandom_range(255)));
        end else begin
            plen = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
            pkt.push_back(8'($urandom_range(255)));
            pkt.push_back(8'h00);
            pkt.push_back(plen[7:0]);
            pkt.push_back(plen[15:8]);
            repeat (plen) pkt.push_back(8'($urandom_range(255)));
            if (kind < 16) drop_last = 1'b1;
            else if (kind < 26) pkt[1] = 8'($urandom_range(255));
            else good_check = 1'b1;
        end
        if (good_check) begin
            saved = dec;
            sum   = 8'h00;
            for (int i = 0; i < pkt.size(); i++) begin
                pr = decrypt_step(pkt[i], i == pkt.size() - 1, start && i == 0);
                if (i >= 4) begin
                    for (int k = 0; k < pr.cnt; k++) sum = sum + pr.ent[k].plain_byte;
                end
            end
            dec    = saved;
            pkt[1] = 8'h00 - sum;
        end
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], !drop_last && i == pkt.size() - 1, start && i == 0, 1'b0, '0);
        pkt_open = drop_last;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_plain.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_session_key(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        dec.sess_key = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver side: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        pdsx_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_plain.size() == 0) begin
                $display("%0t unexpected result: got %h/%b/%b", $realtime,
                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
                n_failures++;
            end else begin
                want = pending_plain.pop_front();
                if (m_axis_tdata !== want.plain_byte || m_axis_tlast !== want.packet_end ||
                    m_axis_tuser !== want.check_error) begin
                    $display("%0t mismatch: expected %h/%b/%b got %h/%b/%b", $realtime,
                             want.plain_byte, want.packet_end, want.check_error,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    n_failures++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int          phase_base;
        bit          hold_done;
        logic [31:0] key_val;
        dec          = '0;
        dec.sess_key = pdsx_pkg::SESSION_KEY_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_byte(DIRECTED[i].cipher, DIRECTED[i].last, DIRECTED[i].start,
                      DIRECTED[i].fixed, DIRECTED[i].want);
        pkt_open = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  key_val = $urandom; end
                1: begin tx_idle_pct = 49; rx_stall_pct = 0;  key_val = 32'h00000000; end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 49; key_val = 32'hFFFFFFFF; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; key_val = $urandom; end
            endcase
            drain_results();
            write_session_key(key_val);
            phase_base = items_sent;
            hold_done  = 1'b0;
            while (items_sent - phase_base < PHASE_ITEMS) begin
                send_packet(pkt_open);
                if (ph == 0 && !hold_done && items_sent - phase_base >= 20) begin
                    rx_hold_req = 1'b1;
                    hold_done   = 1'b1;
                end
            end
        end
        drain_results();

        if (n_failures == 0 && pending_plain.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
